// ----- design/indexed_four_ary_timer_heap_top_macros.svh -----
// ----------------------------------------------------------------------------
// indexed four-ary timer heap assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef INDEXED_FOUR_ARY_TIMER_HEAP_TOP_MACROS_SVH
`define INDEXED_FOUR_ARY_TIMER_HEAP_TOP_MACROS_SVH

// same-cycle implication
`define ITFH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITFH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/itfh_pkg.sv -----
// ----------------------------------------------------------------------------
// itfh_pkg
// shared types and constants of the indexed four-ary timer heap
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itfh_pkg;

  localparam int DEF_CAPACITY = 1024;
  localparam int DEF_ID_COUNT = 1024;
  localparam int DEF_KEY_BITS = 32;

  localparam int ID_BITS = 10;
  localparam int DL_BITS = 32;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic    clr;
    logic    latch;
    logic    upd;
    logic    ins;
    logic    rm_start;
    logic    rm_own;
    logic    rm_last;
    logic    dn_start;
    logic    dn_cmp;
    logic    dn_move;
    logic    up_start;
    logic    up_move;
    logic    place;
    logic    root;
    logic    out_load;
    logic    set_status;
    status_t status_code;
    logic    set_found;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic clr_done;
    logic id_valid;
    logic present;
    logic full;
    logic empty;
    logic rm_single;
    logic dn_child;
    logic dn_more;
    logic best_self;
    logic moved;
    logic at_root;
    logic up_stop;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/itfh_ctrl.sv -----
// ----------------------------------------------------------------------------
// itfh_ctrl
// sequencer: steps the datapath through lookup, removal, sift down, sift up
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itfh_ctrl import itfh_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_LOOK     = 13'b0000000000100,
    S_RM_OWN   = 13'b0000000001000,
    S_RM_LAST  = 13'b0000000010000,
    S_DN_START = 13'b0000000100000,
    S_DN_CMP   = 13'b0000001000000,
    S_DN_MOVE  = 13'b0000010000000,
    S_UP_START = 13'b0000100000000,
    S_UP_CMP   = 13'b0001000000000,
    S_PLACE    = 13'b0010000000000,
    S_ROOT     = 13'b0100000000000,
    S_FIN      = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clr = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_ROOT;
        case (sts.op)
          OP_PUT: begin
            if (!sts.id_valid) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NOT_FOUND;
            end else if (sts.present) begin
              cmd.upd   = 1'b1;
              state_nxt = S_DN_START;
            end else if (sts.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
            end else begin
              cmd.ins   = 1'b1;
              state_nxt = S_UP_START;
            end
          end
          OP_POP: begin
            if (sts.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
            end else begin
              cmd.rm_start = 1'b1;
              state_nxt    = S_RM_OWN;
            end
          end
          OP_REMOVE: begin
            if (sts.present) begin
              cmd.rm_start = 1'b1;
              state_nxt    = S_RM_OWN;
            end else begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_NOT_FOUND;
            end
          end
          default: begin
            cmd.set_found = 1'b1;
          end
        endcase
      end
      S_RM_OWN: begin
        cmd.rm_own = 1'b1;
        state_nxt  = S_RM_LAST;
      end
      S_RM_LAST: begin
        cmd.rm_last = 1'b1;
        state_nxt   = sts.rm_single ? S_ROOT : S_DN_START;
      end
      S_DN_START: begin
        if (sts.dn_child) begin
          cmd.dn_start = 1'b1;
          state_nxt    = S_DN_CMP;
        end else begin
          state_nxt = sts.moved ? S_PLACE : S_UP_START;
        end
      end
      S_DN_CMP: begin
        cmd.dn_cmp = 1'b1;
        if (!sts.dn_more) begin
          state_nxt = S_DN_MOVE;
        end
      end
      S_DN_MOVE: begin
        if (sts.best_self) begin
          state_nxt = sts.moved ? S_PLACE : S_UP_START;
        end else begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_START;
        end
      end
      S_UP_START: begin
        if (sts.at_root) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.up_start = 1'b1;
          state_nxt    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_stop) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_START;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd.root  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/itfh_dp.sv -----
// ----------------------------------------------------------------------------
// itfh_dp
// heap slot memory, id tables, moving-entry registers and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itfh_dp import itfh_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int ID_COUNT = DEF_ID_COUNT,
  parameter int KEY_BITS = DEF_KEY_BITS,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [ID_BITS-1:0] in_timer_id,
  input  wire logic [DL_BITS-1:0] in_deadline,
  output logic [1:0]              out_status,
  output logic                    out_found,
  output logic                    out_min_valid,
  output logic [ID_BITS-1:0]      out_min_id,
  output logic [DL_BITS-1:0]      out_min_deadline,
  output logic [CNT_W-1:0]        out_entry_count
);

  localparam int POS_W = $clog2(CAPACITY);
  localparam int IDX_W = $clog2(ID_COUNT);
  localparam int CW    = POS_W + 3;

  // heap slots and id tables
  logic [KEY_BITS-1:0] slot_key_mem [CAPACITY];
  logic [ID_BITS-1:0]  slot_own_mem [CAPACITY];
  logic [POS_W-1:0]    pos_mem      [ID_COUNT];
  logic                pres_mem     [ID_COUNT];

  logic [KEY_BITS-1:0] slot_key_q;
  logic [ID_BITS-1:0]  slot_own_q;
  logic [POS_W-1:0]    pos_q;
  logic                pres_q;

  op_t                 op_r;
  logic [ID_BITS-1:0]  id_r;
  logic [KEY_BITS-1:0] key_r;
  logic [CNT_W-1:0]    occ_r;
  logic [POS_W-1:0]    cur_pos_r, rm_pos_r, best_pos_r, par_r;
  logic [KEY_BITS-1:0] cur_key_r, best_key_r;
  logic [ID_BITS-1:0]  cur_own_r, best_own_r;
  logic [CW-1:0]       first_r;
  logic [1:0]          k_r;
  logic                moved_r;
  status_t             status_r;
  logic                found_r;
  logic [IDX_W:0]      clr_r;

  logic [CW-1:0]       first_c, child_c, next_c;
  logic [POS_W-1:0]    parent_c, rm_pos_c;
  logic                id_valid_c;
  logic                present_c;

  logic                slot_re, slot_we;
  logic [POS_W-1:0]    slot_raddr, slot_waddr;
  logic [KEY_BITS-1:0] slot_wkey;
  logic [ID_BITS-1:0]  slot_wown;
  logic                pres_we, pres_wdata;
  logic [IDX_W-1:0]    pres_waddr;

  assign first_c    = (CW'(cur_pos_r) << 2) + CW'(1);
  assign child_c    = first_r + CW'(k_r);
  assign next_c     = child_c + CW'(1);
  assign parent_c   = (cur_pos_r - POS_W'(1)) >> 2;
  assign rm_pos_c   = (op_r == OP_POP) ? '0 : pos_q;
  assign id_valid_c = (32'(id_r) < 32'(ID_COUNT));
  assign present_c  = id_valid_c && pres_q && (CNT_W'(pos_q) < occ_r);

  always_comb begin
    sts           = '0;
    sts.op        = op_r;
    sts.clr_done  = (clr_r == (IDX_W + 1)'(ID_COUNT));
    sts.id_valid  = id_valid_c;
    sts.present   = present_c;
    sts.full      = (occ_r == CNT_W'(CAPACITY));
    sts.empty     = (occ_r == '0);
    sts.rm_single = (CNT_W'(rm_pos_r) == occ_r - CNT_W'(1));
    sts.dn_child  = (first_c < CW'(occ_r));
    sts.dn_more   = (k_r != 2'd3) && (next_c < CW'(occ_r));
    sts.best_self = (best_pos_r == cur_pos_r);
    sts.moved     = moved_r;
    sts.at_root   = (cur_pos_r == '0);
    sts.up_stop   = (slot_key_q <= cur_key_r);
  end

  // slot read port
  always_comb begin
    slot_re    = 1'b1;
    slot_raddr = '0;
    if (cmd.rm_start) begin
      slot_raddr = rm_pos_c;
    end else if (cmd.rm_own) begin
      slot_raddr = POS_W'(occ_r - CNT_W'(1));
    end else if (cmd.dn_start) begin
      slot_raddr = POS_W'(first_c);
    end else if (cmd.dn_cmp) begin
      slot_re    = sts.dn_more;
      slot_raddr = POS_W'(next_c);
    end else if (cmd.up_start) begin
      slot_raddr = parent_c;
    end else if (!cmd.root) begin
      slot_re = 1'b0;
    end
  end

  // slot write port, the position table follows each slot write
  always_comb begin
    slot_we    = cmd.dn_move || cmd.up_move || cmd.place;
    slot_waddr = cur_pos_r;
    slot_wkey  = cur_key_r;
    slot_wown  = cur_own_r;
    if (cmd.dn_move) begin
      slot_wkey = best_key_r;
      slot_wown = best_own_r;
    end else if (cmd.up_move) begin
      slot_wkey = slot_key_q;
      slot_wown = slot_own_q;
    end
  end

  always_comb begin
    pres_we    = cmd.clr || cmd.ins || cmd.rm_own;
    pres_waddr = clr_r[IDX_W-1:0];
    pres_wdata = 1'b0;
    if (cmd.ins) begin
      pres_waddr = IDX_W'(id_r);
      pres_wdata = 1'b1;
    end else if (cmd.rm_own) begin
      pres_waddr = IDX_W'(slot_own_q);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_key_mem[slot_waddr] <= slot_wkey;
      slot_own_mem[slot_waddr] <= slot_wown;
      pos_mem[IDX_W'(slot_wown)] <= slot_waddr;
    end
    if (slot_re) begin
      slot_key_q <= slot_key_mem[slot_raddr];
      slot_own_q <= slot_own_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_waddr] <= pres_wdata;
    end
    if (cmd.latch) begin
      pres_q <= pres_mem[IDX_W'(in_timer_id)];
      pos_q  <= pos_mem[IDX_W'(in_timer_id)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.clr) begin
        clr_r <= clr_r + (IDX_W + 1)'(1);
      end
      if (cmd.ins) begin
        occ_r <= occ_r + CNT_W'(1);
      end else if (cmd.rm_last) begin
        occ_r <= occ_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= op_t'(in_opcode);
      id_r     <= in_timer_id;
      key_r    <= KEY_BITS'(in_deadline);
      status_r <= ST_OK;
      found_r  <= 1'b0;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.set_found) begin
      found_r <= present_c;
    end
    if (cmd.upd) begin
      cur_pos_r <= pos_q;
      cur_key_r <= key_r;
      cur_own_r <= id_r;
      moved_r   <= 1'b0;
    end
    if (cmd.ins) begin
      cur_pos_r <= POS_W'(occ_r);
      cur_key_r <= key_r;
      cur_own_r <= id_r;
    end
    if (cmd.rm_start) begin
      rm_pos_r <= rm_pos_c;
    end
    // last entry fills the vacated slot
    if (cmd.rm_last) begin
      cur_pos_r <= rm_pos_r;
      cur_key_r <= slot_key_q;
      cur_own_r <= slot_own_q;
      moved_r   <= 1'b0;
    end
    if (cmd.dn_start) begin
      first_r    <= first_c;
      k_r        <= 2'd0;
      best_pos_r <= cur_pos_r;
      best_key_r <= cur_key_r;
      best_own_r <= cur_own_r;
    end
    // strict compare keeps the first of equal children
    if (cmd.dn_cmp) begin
      if (slot_key_q < best_key_r) begin
        best_pos_r <= POS_W'(child_c);
        best_key_r <= slot_key_q;
        best_own_r <= slot_own_q;
      end
      if (sts.dn_more) begin
        k_r <= k_r + 2'd1;
      end
    end
    if (cmd.dn_move) begin
      cur_pos_r <= best_pos_r;
      moved_r   <= 1'b1;
    end
    if (cmd.up_start) begin
      par_r <= parent_c;
    end
    if (cmd.up_move) begin
      cur_pos_r <= par_r;
    end
    if (cmd.out_load) begin
      out_status       <= status_r;
      out_found        <= found_r;
      out_entry_count  <= occ_r;
      out_min_valid    <= (occ_r != '0);
      out_min_id       <= (occ_r != '0) ? slot_own_q : '0;
      out_min_deadline <= (occ_r != '0) ? DL_BITS'(slot_key_q) : '0;
    end
  end

endmodule

`default_nettype wire

// ----- design/indexed_four_ary_timer_heap_top.sv -----
// each word is looked up first; a query or a rejected word then only reads the root,
// an insert or update sifts, a pop or remove moves the last entry into the vacated slot
// and then sifts (no sift when the last entry itself goes); sift down reads each child
// of a level in turn, sift up compares one parent per step, stopping at the root
// one word in flight at a time: in_stall is high whenever the sequencer is not idle
// after reset in_stall stays high while the presence table is swept
`timescale 1ns / 1ps
`default_nettype none

module indexed_four_ary_timer_heap_top import itfh_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int ID_COUNT = DEF_ID_COUNT,
  parameter int KEY_BITS = DEF_KEY_BITS,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [ID_BITS-1:0] in_timer_id,
  input  wire logic [DL_BITS-1:0] in_deadline,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic                    out_found,
  output logic                    out_min_valid,
  output logic [ID_BITS-1:0]      out_min_id,
  output logic [DL_BITS-1:0]      out_min_deadline,
  output logic [CNT_W-1:0]        out_entry_count
);

  cmd_t cmd;
  sts_t sts;

  itfh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  itfh_dp #(
    .CAPACITY (CAPACITY),
    .ID_COUNT (ID_COUNT),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_timer_id      (in_timer_id),
    .in_deadline      (in_deadline),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_min_valid    (out_min_valid),
    .out_min_id       (out_min_id),
    .out_min_deadline (out_min_deadline),
    .out_entry_count  (out_entry_count)
  );

endmodule

`default_nettype wire

// ----- design/itfh_checker.sv -----
// ----------------------------------------------------------------------------
// itfh_checker
// port-level checks of the timer heap results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_four_ary_timer_heap_top_macros.svh"

module itfh_checker import itfh_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_status,
  input wire logic               out_found,
  input wire logic               out_min_valid,
  input wire logic [ID_BITS-1:0] out_min_id,
  input wire logic [DL_BITS-1:0] out_min_deadline,
  input wire logic [CNT_W-1:0]   out_entry_count
);

  `ITFH_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_entry_count) && $stable(out_min_deadline), "stalled word changed")
  `ITFH_ASSERT_IMP(a_count_max, out_valid, out_entry_count <= CNT_W'(CAPACITY), "count beyond capacity")
  `ITFH_ASSERT_IMP(a_min_valid, out_valid, out_min_valid == (out_entry_count != '0), "min_valid disagrees with count")
  `ITFH_ASSERT_IMP(a_empty_zero, out_valid && !out_min_valid, out_min_id == '0 && out_min_deadline == '0, "empty heap shows a root")
  `ITFH_ASSERT_IMP(a_full_count, out_valid && out_status == ST_FULL, out_entry_count == CNT_W'(CAPACITY) && !out_found, "full status below capacity")

endmodule

bind indexed_four_ary_timer_heap_top itfh_checker #(
  .CAPACITY (CAPACITY)
) u_itfh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_found        (out_found),
  .out_min_valid    (out_min_valid),
  .out_min_id       (out_min_id),
  .out_min_deadline (out_min_deadline),
  .out_entry_count  (out_entry_count)
);

`default_nettype wire

// ----- tb/tb_indexed_four_ary_timer_heap_top.sv -----
// ----------------------------------------------------------------------------
// tb_indexed_four_ary_timer_heap_top
// drives put, pop, remove and query words into the timer heap and checks each
// result word against an in-bench indexed four-ary heap predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_indexed_four_ary_timer_heap_top;
  import itfh_pkg::*;

  localparam int CAP     = 1024;
  localparam int NUM_IDS = 1024;
  localparam int CNT_W   = 11;
  localparam int CYCLE_LIMIT = 900000;

  typedef struct packed {
    op_t               op;
    logic [ID_BITS-1:0] id;
    logic [DL_BITS-1:0] dl;
  } heap_cmd_t;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic               min_valid;
    logic [ID_BITS-1:0] min_id;
    logic [DL_BITS-1:0] min_dl;
    logic [CNT_W-1:0]   count;
  } heap_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [ID_BITS-1:0] in_timer_id = '0;
  logic [DL_BITS-1:0] in_deadline = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic out_found;
  logic out_min_valid;
  logic [ID_BITS-1:0] out_min_id;
  logic [DL_BITS-1:0] out_min_deadline;
  logic [CNT_W-1:0] out_entry_count;

  indexed_four_ary_timer_heap_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_timer_id(in_timer_id), .in_deadline(in_deadline),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_found(out_found), .out_min_valid(out_min_valid),
    .out_min_id(out_min_id), .out_min_deadline(out_min_deadline),
    .out_entry_count(out_entry_count)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [DL_BITS-1:0] slot_dl [CAP];
  logic [ID_BITS-1:0] slot_id [CAP];
  int                 id_slot [NUM_IDS];
  bit                 id_live [NUM_IDS];
  int                 heap_size;

  heap_cmd_t  pending_cmds [$];
  heap_resp_t expected_resps [$];
  int  mismatches = 0;
  bit  stim_done = 1'b0;
  int  cycle_count = 0;

  function automatic void add_word(heap_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [DL_BITS-1:0] d;
    logic [ID_BITS-1:0] o;
    d = slot_dl[a]; o = slot_id[a];
    slot_dl[a] = slot_dl[b]; slot_id[a] = slot_id[b];
    slot_dl[b] = d; slot_id[b] = o;
    id_slot[slot_id[a]] = a;
    id_slot[slot_id[b]] = b;
  endfunction

  function automatic int sink(int pos);
    int i, moves, best, k;
    i = pos;
    moves = 0;
    while (i * 4 + 1 < heap_size) begin
      best = i;
      for (k = i * 4 + 1; k < heap_size && k < i * 4 + 5; k++)
        if (slot_dl[k] < slot_dl[best]) best = k;
      if (best == i) break;
      swap_slots(i, best);
      i = best;
      moves++;
    end
    return moves;
  endfunction

  function automatic void rise(int pos);
    int i, p;
    i = pos;
    while (i > 0) begin
      p = (i - 1) / 4;
      if (slot_dl[p] <= slot_dl[i]) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic void settle(int pos);
    if (sink(pos) == 0) rise(pos);
  endfunction

  function automatic void evict(int pos);
    int last;
    last = heap_size - 1;
    if (pos < last) swap_slots(pos, last);
    id_live[slot_id[last]] = 1'b0;
    heap_size = last;
    if (pos < heap_size) settle(pos);
  endfunction

  function automatic heap_resp_t heap_apply(heap_cmd_t c);
    heap_resp_t r;
    bit live;
    r = '0;
    r.status = ST_OK;
    live = id_live[c.id] && id_slot[c.id] < heap_size;
    case (c.op)
      OP_PUT: begin
        if (live) begin
          slot_dl[id_slot[c.id]] = c.dl;
          settle(id_slot[c.id]);
        end else if (heap_size >= CAP) begin
          r.status = ST_FULL;
        end else begin
          slot_dl[heap_size] = c.dl;
          slot_id[heap_size] = c.id;
          id_slot[c.id] = heap_size;
          id_live[c.id] = 1'b1;
          heap_size++;
          rise(heap_size - 1);
        end
      end
      OP_POP: begin
        if (heap_size == 0) r.status = ST_EMPTY;
        else evict(0);
      end
      OP_REMOVE: begin
        if (live) evict(id_slot[c.id]);
        else r.status = ST_NOT_FOUND;
      end
      default: r.found = live;
    endcase
    r.min_valid = heap_size > 0;
    r.min_id    = heap_size > 0 ? slot_id[0] : '0;
    r.min_dl    = heap_size > 0 ? slot_dl[0] : '0;
    r.count     = heap_size[CNT_W-1:0];
    return r;
  endfunction

  function automatic heap_cmd_t mk(op_t op, int id, logic [DL_BITS-1:0] dl);
    heap_cmd_t c;
    c.op = op;
    c.id = id[ID_BITS-1:0];
    c.dl = dl;
    return c;
  endfunction

  // random deadline: mostly narrow so ties happen, sometimes full width
  function automatic logic [DL_BITS-1:0] rand_dl();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return $urandom;
      default: return $urandom_range(0, 4000);
    endcase
  endfunction

  initial begin
    int n, mode;
    op_t op;
    add_word(mk(OP_POP, 0, 0));
    add_word(mk(OP_REMOVE, 5, 0));
    add_word(mk(OP_QUERY, 1023, 0));
    add_word(mk(OP_PUT, 1023, 32'hFFFF_FFFF));
    add_word(mk(OP_PUT, 0, 32'd0));
    add_word(mk(OP_PUT, 7, 32'd100));
    add_word(mk(OP_PUT, 8, 32'd100));
    add_word(mk(OP_PUT, 9, 32'd50));
    add_word(mk(OP_PUT, 10, 32'd75));
    add_word(mk(OP_PUT, 11, 32'd100));
    add_word(mk(OP_QUERY, 7, 0));
    add_word(mk(OP_QUERY, 6, 0));
    add_word(mk(OP_PUT, 0, 32'd200));      // update moves down
    add_word(mk(OP_PUT, 1023, 32'd1));     // update moves up
    add_word(mk(OP_PUT, 8, 32'd100));      // update stays
    add_word(mk(OP_REMOVE, 9, 0));
    add_word(mk(OP_REMOVE, 9, 0));
    add_word(mk(OP_POP, 0, 0));
    add_word(mk(OP_PUT, 682, 32'hAAAA_5555));
    add_word(mk(OP_PUT, 341, 32'h5555_AAAA));
    add_word(mk(OP_QUERY, 1023, 0));
    // fill to capacity
    for (int i = 0; i < NUM_IDS; i++)
      add_word(mk(OP_PUT, i, rand_dl()));
    for (int i = 0; i < 30; i++)
      add_word(mk(op_t'($urandom_range(0, 3)), $urandom_range(0, 1023), rand_dl()));
    for (int i = 0; i < 200; i++)
      add_word(mk(OP_POP, 0, 0));
    n = 0;
    while (n < 475) begin
      mode = $urandom_range(0, 9);
      // small id pool keeps hits likely for update, remove and query
      if (mode < 4) op = OP_PUT;
      else if (mode < 6) op = OP_POP;
      else if (mode < 8) op = OP_REMOVE;
      else op = OP_QUERY;
      add_word(mk(op,
        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63),
        rand_dl()));
      n++;
    end
  end

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    heap_cmd_t c;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      expected_resps.insert(expected_resps.size(), heap_apply(pending_cmds.pop_front()));
      in_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      if (in_gap == 0 && pending_cmds.size() > 0) begin
        c = pending_cmds[0];
        in_opcode <= c.op; in_timer_id <= c.id; in_deadline <= c.dl;
      end else begin
        in_valid <= 1'b0;
        if (pending_cmds.size() == 0) stim_done = 1'b1;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds[0];
        in_valid <= 1'b1;
        in_opcode <= c.op; in_timer_id <= c.id; in_deadline <= c.dl;
      end
    end
  end

  // monitor
  int out_hold = 0;
  always @(posedge clk) begin
    heap_resp_t want, got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status = status_t'(out_status);
        got.found = out_found;
        got.min_valid = out_min_valid;
        got.min_id = out_min_id;
        got.min_dl = out_min_deadline;
        got.count = out_entry_count;
        if (expected_resps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", got);
        end else begin
          want = expected_resps.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p got %p", want, got);
          end
        end
        out_hold = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NUM_IDS; i++) id_live[i] = 1'b0;
    heap_size = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected_resps.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_resps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
